@@ hdl/falloc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// falloc_pkg
// shared constants, types and mask helpers for the first-fit slot allocator
// ----------------------------------------------------------------------------
package falloc_pkg;

	localparam int NUM_ROOMS   = 4096;
	localparam int BUCKET_SIZE = 64;
	localparam int FIELD_W     = 13;
	localparam int ROW_W       = BUCKET_SIZE;
	localparam int NUM_ROWS    = NUM_ROOMS / BUCKET_SIZE;
	localparam int ROW_AW      = $clog2(NUM_ROWS);
	localparam int BIT_AW      = $clog2(BUCKET_SIZE);
	localparam int SLOT_AW     = ROW_AW + BIT_AW;
	localparam int ROWSEL_W    = FIELD_W - BIT_AW;

	localparam logic [FIELD_W-1:0] MAX_LIMIT = FIELD_W'(NUM_ROOMS);

	// scan modes of the shared unit
	localparam logic MODE_SEEK_FREE = 1'b0;
	localparam logic MODE_SEEK_OCC  = 1'b1;

	typedef struct packed {
		logic              found;  // a matching bit at or above the start bit
		logic [BIT_AW-1:0] idx;    // lowest matching bit
		logic              fit;    // free run from run start reaches count
	} scan_res_t;

	// bits of a row whose slot index is >= x
	function automatic logic [ROW_W-1:0] ge_mask(input logic [ROW_AW-1:0] row,
			input logic [FIELD_W-1:0] x);
		logic [ROWSEL_W-1:0] xr;
		logic [ROWSEL_W-1:0] rr;
		logic [ROW_W-1:0]    m;
		xr = x[FIELD_W-1:BIT_AW];
		rr = ROWSEL_W'(row);
		if (xr > rr) begin
			m = '0;
		end else if (xr < rr) begin
			m = '1;
		end else begin
			m = {ROW_W{1'b1}} << x[BIT_AW-1:0];
		end
		return m;
	endfunction

	// lowest set bit of a row
	function automatic logic [BIT_AW-1:0] first_set(input logic [ROW_W-1:0] v);
		logic [BIT_AW-1:0] idx;
		idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_AW'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

@@ hdl/falloc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// falloc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module falloc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/falloc_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// falloc_unit
// shared scan unit: masked priority search over one row and run-length check
// ----------------------------------------------------------------------------
module falloc_unit (
	input  wire logic [falloc_pkg::ROW_AW-1:0]  row,
	input  wire logic [falloc_pkg::BIT_AW-1:0]  start_bit,
	input  wire logic [falloc_pkg::ROW_W-1:0]   row_bits,
	input  wire logic [falloc_pkg::FIELD_W-1:0] lim,
	input  wire logic                           mode,
	input  wire logic [falloc_pkg::SLOT_AW-1:0] run_start,
	input  wire logic [falloc_pkg::FIELD_W-1:0] need,
	output falloc_pkg::scan_res_t               res
);
	import falloc_pkg::*;

	logic [ROW_W-1:0]   eff;
	logic [ROW_W-1:0]   cand;
	logic [BIT_AW-1:0]  idx;
	logic [BIT_AW:0]    stop_bit;
	logic [FIELD_W-1:0] stop_pos;
	logic [FIELD_W-1:0] run_len;

	// slots above the managed limit read as occupied
	assign eff  = row_bits | ge_mask(row, lim);
	assign cand = ((mode == MODE_SEEK_OCC) ? eff : ~eff) & ({ROW_W{1'b1}} << start_bit);
	assign idx  = first_set(cand);

	// free run ends at the first occupied bit, or at the row end
	assign stop_bit = (cand != '0) ? {1'b0, idx} : (BIT_AW + 1)'(ROW_W);
	assign stop_pos = FIELD_W'({row, {BIT_AW{1'b0}}}) + FIELD_W'(stop_bit);
	assign run_len  = stop_pos - FIELD_W'(run_start);

	assign res.found = (cand != '0);
	assign res.idx   = idx;
	assign res.fit   = (run_len >= need);

endmodule
`default_nettype wire

@@ hdl/first_fit_contiguous_range_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_contiguous_range_allocator_top
// first-fit allocator of consecutive slots over a 4096-slot occupancy bitmap
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                 payload
// -------  ---------  ------------------------  -----------------------------
// in       input      in_valid / in_stall       kind, count, first_room
// out      output     out_valid / out_stall     start_room
// cfg      input      cfg_we (no wait)          cfg_wdata -> room_count
//
// an allocate item reads and scans each bitmap row visited, with a further
// scan step per free/occupied boundary crossed, then marks each row (ram
// read and write) and loads the output register; one shared row scan unit searches.
// a release item does a ram read-modify-write of each row it touches.
// reset marks all 64 rows not written, so they read free: no clearing pass.
// a result waits in the output register; a new item is taken meanwhile, and
// an allocate only holds in its last state while the register is full and stalled.
//
module first_fit_contiguous_range_allocator_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input items
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           kind,
	input  wire logic [falloc_pkg::FIELD_W-1:0] count,
	input  wire logic [falloc_pkg::FIELD_W-1:0] first_room,
	// result items
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [falloc_pkg::FIELD_W-1:0] start_room,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [falloc_pkg::FIELD_W-1:0] cfg_wdata
);
	import falloc_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an item
	localparam logic [2:0] ST_RD   = 3'd1;  // ram read of the scan row
	localparam logic [2:0] ST_SCAN = 3'd2;  // one search step per cycle
	localparam logic [2:0] ST_MRD  = 3'd3;  // ram read of a row to update
	localparam logic [2:0] ST_MWR  = 3'd4;  // write back the updated row
	localparam logic [2:0] ST_OUT  = 3'd5;  // hand result to output register

	logic [2:0]         state_q;
	logic [FIELD_W-1:0] room_count_q;
	logic [NUM_ROWS-1:0] row_valid_q;   // row has been written since reset

	logic [ROW_AW-1:0]  row_q;
	logic [BIT_AW-1:0]  bit_q;
	logic               mode_q;
	logic [SLOT_AW-1:0] rs_q;           // zero-based start of current free run
	logic [FIELD_W-1:0] need_q;
	logic [SLOT_AW-1:0] lo_q;           // zero-based update range
	logic [SLOT_AW-1:0] hi_q;
	logic               alloc_q;        // update sets bits (allocate) or clears
	logic [FIELD_W-1:0] res_q;

	logic               out_valid_q;
	logic [FIELD_W-1:0] start_room_q;

	// ram port
	logic               ram_we;
	logic [ROW_W-1:0]   ram_wdata;
	logic [ROW_W-1:0]   ram_rdata;
	logic [ROW_W-1:0]   row_bits;

	// helpers
	logic [FIELD_W-1:0] lim;
	logic               accept;
	logic [FIELD_W:0]   rel_hi1;        // one-based last slot of a release
	logic [FIELD_W:0]   rel_hi_clip;
	logic [FIELD_W-1:0] rel_lo1;
	logic               rel_skip;
	logic [FIELD_W-1:0] next_base;
	logic [SLOT_AW-1:0] alloc_hi;
	logic [ROW_W-1:0]   upd_mask;
	logic               out_free;
	scan_res_t          sres;

	// managed limit, capped at the bitmap size
	assign lim = (room_count_q > MAX_LIMIT) ? MAX_LIMIT : room_count_q;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// release range, clipped to slots 1..lim
	assign rel_hi1     = (FIELD_W + 1)'(first_room) + (FIELD_W + 1)'(count)
			- (FIELD_W + 1)'(1);
	assign rel_hi_clip = (rel_hi1 > (FIELD_W + 1)'(lim)) ? (FIELD_W + 1)'(lim) : rel_hi1;
	assign rel_lo1     = (first_room == '0) ? FIELD_W'(1) : first_room;
	assign rel_skip    = (count == '0) || ((FIELD_W + 1)'(rel_lo1) > rel_hi_clip);

	// first slot of the row after the scan row
	assign next_base = FIELD_W'({(ROWSEL_W)'(row_q) + ROWSEL_W'(1), {BIT_AW{1'b0}}});

	assign alloc_hi = rs_q + SLOT_AW'(need_q) - SLOT_AW'(1);

	// rows never written read free
	assign row_bits = row_valid_q[row_q] ? ram_rdata : '0;

	// bits of the current row inside the update range
	assign upd_mask = ge_mask(row_q, FIELD_W'(lo_q))
			& ~ge_mask(row_q, FIELD_W'(hi_q) + FIELD_W'(1));

	assign ram_we    = (state_q == ST_MWR);
	assign ram_wdata = alloc_q ? (row_bits | upd_mask) : (row_bits & ~upd_mask);

	falloc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (ram_wdata),
		.raddr (row_q),
		.rdata (ram_rdata)
	);

	falloc_unit u_unit (
		.row       (row_q),
		.start_bit (bit_q),
		.row_bits  (row_bits),
		.lim       (lim),
		.mode      (mode_q),
		.run_start (rs_q),
		.need      (need_q),
		.res       (sres)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= MAX_LIMIT;
		end else if (cfg_we) begin
			room_count_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!kind) begin
							// allocate: trivial misses answer at once
							if ((count == '0) || (count > lim)) begin
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_RD;
							end
						end else if (!rel_skip) begin
							state_q <= ST_MRD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (mode_q == MODE_SEEK_FREE) begin
						if (!sres.found) begin
							if ((row_q == ROW_AW'(NUM_ROWS - 1)) || (next_base >= lim)) begin
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_RD;
							end
						end
					end else begin
						if (sres.fit) begin
							state_q <= ST_MRD;
						end else if (!sres.found) begin
							if (row_q == ROW_AW'(NUM_ROWS - 1)) begin
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_RD;
							end
						end
					end
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					row_valid_q[row_q] <= 1'b1;
					if (row_q == hi_q[SLOT_AW-1:BIT_AW]) begin
						state_q <= alloc_q ? ST_OUT : ST_IDLE;
					end else begin
						state_q <= ST_MRD;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan and update datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					need_q  <= count;
					alloc_q <= !kind;
					res_q   <= '0;
					if (!kind) begin
						row_q  <= '0;
						bit_q  <= '0;
						rs_q   <= '0;
						mode_q <= MODE_SEEK_FREE;
					end else begin
						lo_q  <= SLOT_AW'(rel_lo1 - FIELD_W'(1));
						hi_q  <= SLOT_AW'(rel_hi_clip - (FIELD_W + 1)'(1));
						row_q <= rel_lo1[FIELD_W-1:BIT_AW] == '0 ? '0
								: ROW_AW'((rel_lo1 - FIELD_W'(1)) >> BIT_AW);
					end
				end
			end
			ST_SCAN: begin
				if (mode_q == MODE_SEEK_FREE) begin
					if (sres.found) begin
						// free run opens here
						rs_q   <= {row_q, sres.idx};
						bit_q  <= sres.idx;
						mode_q <= MODE_SEEK_OCC;
					end else begin
						row_q <= row_q + ROW_AW'(1);
						bit_q <= '0;
					end
				end else begin
					if (sres.fit) begin
						res_q <= FIELD_W'(rs_q) + FIELD_W'(1);
						lo_q  <= rs_q;
						hi_q  <= alloc_hi;
						row_q <= rs_q[SLOT_AW-1:BIT_AW];
					end else if (sres.found) begin
						// run too short, look for the next free slot
						bit_q  <= sres.idx;
						mode_q <= MODE_SEEK_FREE;
					end else begin
						row_q <= row_q + ROW_AW'(1);
						bit_q <= '0;
					end
				end
			end
			ST_MWR: begin
				if (row_q != hi_q[SLOT_AW-1:BIT_AW]) begin
					row_q <= row_q + ROW_AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			start_room_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign start_room = start_room_q;

endmodule
`default_nettype wire
